>>> rtl/tzcl_pkg.sv
// thermal zone current limiter: shared widths, reset values, register indexes and types
// no dependencies
`default_nettype none

package tzcl_pkg;

	localparam int TEMP_W     = 9;
	localparam int LIMIT_W    = 12;
	localparam int CNT_W      = 3;
	localparam int ZONE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int WINDOW_DEF = 5;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic signed [TEMP_W-1:0] RISE_TO_ONE_RST  = 9'sd53;
	localparam logic signed [TEMP_W-1:0] RISE_TO_TWO_RST  = 9'sd70;
	localparam logic signed [TEMP_W-1:0] FALL_TO_ZERO_RST = 9'sd48;
	localparam logic signed [TEMP_W-1:0] FALL_TO_ONE_RST  = 9'sd65;
	localparam logic [LIMIT_W-1:0]       LIMIT_ONE_RST    = 12'd1000;
	localparam logic [LIMIT_W-1:0]       LIMIT_TWO_RST    = 12'd500;
	localparam logic [CNT_W-1:0]         CONFIRM_RST      = 3'd3;

	localparam logic [ZONE_W-1:0] ZONE_NONE   = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_MEDIUM = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_HOT    = 2'd2;

	localparam logic ROW_RISE = 1'b0;
	localparam logic ROW_FALL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RISE_TO_ONE,
		CFG_RISE_TO_TWO,
		CFG_FALL_TO_ZERO,
		CFG_FALL_TO_ONE,
		CFG_LIMIT_ONE,
		CFG_LIMIT_TWO,
		CFG_CONFIRM
	} tzcl_cfg_idx_t;

	// travels alongside a sum through the averaging pipeline
	typedef struct packed {
		logic vld;
		logic last_nz;
	} tzcl_tag_t;

	typedef struct packed {
		logic [ZONE_W-1:0]        zone;
		logic                     limited;
		logic [LIMIT_W-1:0]       limit;
		logic signed [TEMP_W-1:0] avg;
	} tzcl_result_t;

endpackage

`default_nettype wire

>>> rtl/tzcl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tzcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/tzcl_avg.sv
// rounded window average, trunc((2*sum+window)/(2*window)), three pipeline stages
// depends on tzcl_pkg
`default_nettype none

module tzcl_avg import tzcl_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int SUM_W  = TEMP_W + $clog2(WINDOW)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire tzcl_tag_t                tag_in,
	input  wire logic signed [SUM_W-1:0]  sum_in,
	output tzcl_tag_t                     tag_out,
	output logic signed [TEMP_W-1:0]      avg_out
);

	localparam int DIVISOR = 2 * WINDOW;
	localparam int NUM_W   = SUM_W + 2;
	localparam int SHIFT   = NUM_W + $clog2(DIVISOR) + 1;
	localparam int MULT_W  = SHIFT + 1;
	localparam int PROD_W  = NUM_W + MULT_W;
	// ceil(2^SHIFT / divisor): exact floor for every numerator magnitude
	localparam logic [MULT_W-1:0] RECIP = MULT_W'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);

	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]        mag;
	logic [TEMP_W-1:0]       quot;

	logic [NUM_W-1:0]  mag_s1;
	logic              neg_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;
	tzcl_tag_t         tag_s1, tag_s2;

	assign num  = (NUM_W'(sum_in) <<< 1) + NUM_W'(WINDOW);
	assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign quot = prod_s2[SHIFT +: TEMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_out <= '0;
		end else begin
			tag_s1  <= tag_in;
			tag_s2  <= tag_s1;
			tag_out <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		neg_s1  <= num[NUM_W-1];
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(RECIP);
		neg_s2  <= neg_s1;
		// truncation toward zero: divide the magnitude, then restore the sign
		avg_out <= neg_s2 ? -$signed(quot) : $signed(quot);
	end

endmodule

`default_nettype wire

>>> rtl/thermal_zone_current_limiter.sv
// thermal zone current limiter top level: sample ring, averaging, zone qualification
// depends on tzcl_pkg, tzcl_ram, tzcl_avg
`default_nettype none

// usage
//  - input channel (in_valid / in_ready / temp_celsius): one signed temperature word
//    per tick; every accepted word yields exactly one result word
//  - output channel (out_valid / out_ready): zone, limited flag, current limit in mA
//    and the rounded average of the last WINDOW samples
//  - config port: cfg_wr_en writes cfg_wdata into register cfg_idx at the clock edge;
//    write only while no word is in flight
//  - throughput: one word per cycle while in_ready is high; the ring memory turns a read
//    at accept into a write in the next cycle, and the running sum is updated once per word
//  - path from accept to out_valid: sum update, three averaging stages, zone update
//    into the output queue; the ring read rides the accept edge
//  - the output queue holds eight words; in_ready drops only when eight words are
//    accepted but not yet taken, so a stalled receiver backs up into the input
//  - reset: ring reads as zero through per-entry valid bits, sum, average,
//    direction flag, qualification counters and zone all cleared, registers take
//    their default thresholds and limits

module thermal_zone_current_limiter import tzcl_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [TEMP_W-1:0]  temp_celsius,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [ZONE_W-1:0]              zone,
	output logic                           limited,
	output logic [LIMIT_W-1:0]             current_limit_ma,
	output logic signed [TEMP_W-1:0]       average_celsius,
	input  wire logic                      cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int PTR_W = $clog2(WINDOW);
	localparam int SUM_W = TEMP_W + $clog2(WINDOW);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);

	// configuration registers
	logic signed [TEMP_W-1:0] rise_one_q, rise_two_q, fall_zero_q, fall_one_q;
	logic [LIMIT_W-1:0]       limit_one_q, limit_two_q;
	logic [CNT_W-1:0]         confirm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_one_q  <= RISE_TO_ONE_RST;
			rise_two_q  <= RISE_TO_TWO_RST;
			fall_zero_q <= FALL_TO_ZERO_RST;
			fall_one_q  <= FALL_TO_ONE_RST;
			limit_one_q <= LIMIT_ONE_RST;
			limit_two_q <= LIMIT_TWO_RST;
			confirm_q   <= CONFIRM_RST;
		end else if (cfg_wr_en) begin
			case (tzcl_cfg_idx_t'(cfg_idx))
				CFG_RISE_TO_ONE:  rise_one_q  <= cfg_wdata[TEMP_W-1:0];
				CFG_RISE_TO_TWO:  rise_two_q  <= cfg_wdata[TEMP_W-1:0];
				CFG_FALL_TO_ZERO: fall_zero_q <= cfg_wdata[TEMP_W-1:0];
				CFG_FALL_TO_ONE:  fall_one_q  <= cfg_wdata[TEMP_W-1:0];
				CFG_LIMIT_ONE:    limit_one_q <= cfg_wdata[LIMIT_W-1:0];
				CFG_LIMIT_TWO:    limit_two_q <= cfg_wdata[LIMIT_W-1:0];
				CFG_CONFIRM:      confirm_q   <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// accept and ring read
	logic                       in_acc;
	logic [FIFO_AW:0]           outstanding_q;
	logic                       out_deq;
	logic [PTR_W-1:0]           ptr_q;
	logic [PTR_W-1:0]           ptr_s1;
	logic                       vld_s1;
	logic signed [TEMP_W-1:0]   temp_s1;
	logic [TEMP_W-1:0]          ram_rdata;

	assign in_ready = outstanding_q < (FIFO_AW+1)'(FIFO_DEPTH);
	assign in_acc   = in_valid && in_ready;
	assign out_deq  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			ptr_q         <= '0;
			vld_s1        <= 1'b0;
		end else begin
			if (in_acc && !out_deq) begin
				outstanding_q <= outstanding_q + 1'b1;
			end else if (!in_acc && out_deq) begin
				outstanding_q <= outstanding_q - 1'b1;
			end
			if (in_acc) begin
				ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
			end
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		ptr_s1  <= ptr_q;
		temp_s1 <= temp_celsius;
	end

	// the oldest sample is read at accept and overwritten in the next cycle
	tzcl_ram #(
		.WIDTH (TEMP_W),
		.DEPTH (WINDOW),
		.AW    (PTR_W)
	) u_ring (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (ptr_s1),
		.wdata (temp_s1),
		.re    (in_acc),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// running sum update, entries never written read as zero
	logic [WINDOW-1:0]         ring_vld_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      last_nz_q;
	logic signed [TEMP_W-1:0]  old_sample;
	logic signed [SUM_W-1:0]   sum_nxt;
	logic                      last_nz_nxt;
	logic signed [SUM_W-1:0]   sum_s2;
	tzcl_tag_t                 tag_s2;

	assign old_sample  = ring_vld_q[ptr_s1] ? $signed(ram_rdata) : '0;
	assign sum_nxt     = sum_q + SUM_W'(temp_s1) - SUM_W'(old_sample);
	// the last ring slot gates qualification while it does not hold a nonzero sample
	assign last_nz_nxt = (ptr_s1 == LAST_IDX) ? (temp_s1 != '0) : last_nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			sum_q      <= '0;
			last_nz_q  <= 1'b0;
			tag_s2     <= '0;
		end else begin
			if (vld_s1) begin
				ring_vld_q[ptr_s1] <= 1'b1;
				sum_q              <= sum_nxt;
				last_nz_q          <= last_nz_nxt;
			end
			tag_s2.vld     <= vld_s1;
			tag_s2.last_nz <= last_nz_nxt;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_nxt;
	end

	// rounded average
	tzcl_tag_t                avg_tag;
	logic signed [TEMP_W-1:0] avg;

	tzcl_avg #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_s2),
		.sum_in  (sum_s2),
		.tag_out (avg_tag),
		.avg_out (avg)
	);

	// direction, qualification counters and zone
	logic signed [TEMP_W-1:0] last_avg_q;
	logic                     rising_q;
	logic [ZONE_W-1:0]        zone_q;
	logic [CNT_W-1:0]         cnt_q    [2][3];
	logic [CNT_W-1:0]         cnt_bump [2][3];
	logic [CNT_W-1:0]         cnt_nxt  [2][3];
	logic                     rising_nxt;
	logic                     hit;
	logic                     hit_row;
	logic [1:0]               hit_col;
	logic [CNT_W-1:0]         need;
	logic [ZONE_W-1:0]        zone_nxt;
	tzcl_result_t             res;

	always_comb begin
		if (avg > last_avg_q) begin
			rising_nxt = 1'b1;
		end else if (avg < last_avg_q) begin
			rising_nxt = 1'b0;
		end else begin
			rising_nxt = rising_q;
		end

		// at most one threshold hit per word, checked against the present zone
		hit     = 1'b0;
		hit_row = ROW_RISE;
		hit_col = 2'(ZONE_NONE);
		if (avg_tag.last_nz) begin
			if (rising_nxt) begin
				if (avg >= rise_two_q && zone_q <= ZONE_HOT) begin
					hit     = 1'b1;
					hit_col = 2'(ZONE_HOT);
				end else if (avg >= rise_one_q && zone_q <= ZONE_MEDIUM) begin
					hit     = 1'b1;
					hit_col = 2'(ZONE_MEDIUM);
				end
			end else begin
				hit_row = ROW_FALL;
				if (avg < fall_zero_q && zone_q >= ZONE_MEDIUM) begin
					hit     = 1'b1;
					hit_col = 2'(ZONE_NONE);
				end else if (avg < fall_one_q && zone_q >= ZONE_HOT) begin
					hit     = 1'b1;
					hit_col = 2'(ZONE_MEDIUM);
				end
			end
		end

		// a hit bumps its counter, saturating, and clears every other one
		for (int r = 0; r < 2; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!hit) begin
					cnt_bump[r][c] = cnt_q[r][c];
				end else if (r == int'(hit_row) && c == int'(hit_col)) begin
					cnt_bump[r][c] = (cnt_q[r][c] == '1) ? cnt_q[r][c] : cnt_q[r][c] + 1'b1;
				end else begin
					cnt_bump[r][c] = '0;
				end
			end
		end

		need     = (confirm_q == '0) ? CNT_W'(1) : confirm_q;
		zone_nxt = zone_q;
		cnt_nxt  = cnt_bump;
		// later column wins, rise counter before fall counter within a column
		for (int c = 0; c < 3; c++) begin
			if (cnt_bump[0][c] == need) begin
				zone_nxt      = ZONE_W'(c);
				cnt_nxt[0][c] = '0;
			end else if (cnt_bump[1][c] == need) begin
				zone_nxt      = ZONE_W'(c);
				cnt_nxt[1][c] = '0;
			end
		end

		res.zone    = zone_nxt;
		res.limited = (zone_nxt == ZONE_MEDIUM) || (zone_nxt == ZONE_HOT);
		if (zone_nxt == ZONE_MEDIUM) begin
			res.limit = limit_one_q;
		end else if (zone_nxt == ZONE_HOT) begin
			res.limit = limit_two_q;
		end else begin
			res.limit = '0;
		end
		res.avg = avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_avg_q <= '0;
			rising_q   <= 1'b0;
			zone_q     <= ZONE_NONE;
			for (int r = 0; r < 2; r++) begin
				for (int c = 0; c < 3; c++) begin
					cnt_q[r][c] <= '0;
				end
			end
		end else if (avg_tag.vld) begin
			last_avg_q <= avg;
			rising_q   <= rising_nxt;
			zone_q     <= zone_nxt;
			cnt_q      <= cnt_nxt;
		end
	end

	// output queue, sized to cover every word the input side may have in flight
	tzcl_result_t       fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   fifo_cnt_q;
	tzcl_result_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (avg_tag.vld) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (avg_tag.vld && !out_deq) begin
				fifo_cnt_q <= fifo_cnt_q + 1'b1;
			end else if (!avg_tag.vld && out_deq) begin
				fifo_cnt_q <= fifo_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (avg_tag.vld) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign head             = fifo_q[rd_ptr_q];
	assign out_valid        = fifo_cnt_q != '0;
	assign zone             = head.zone;
	assign limited          = head.limited;
	assign current_limit_ma = head.limit;
	assign average_celsius  = head.avg;

	// checks
	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("more words in flight than the output queue holds");

	a_queue_within_flight: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= outstanding_q)
		else $error("output queue holds more words than were accepted");

	a_ring_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && vld_s1) |-> (ptr_q != ptr_s1))
		else $error("ring read and write hit the same entry");

	a_single_counter: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cnt_q[0][0] != '0, cnt_q[0][1] != '0, cnt_q[0][2] != '0,
			cnt_q[1][0] != '0, cnt_q[1][1] != '0, cnt_q[1][2] != '0}) <= 1)
		else $error("more than one qualification counter active");

endmodule

`default_nettype wire

>>> tb/thermal_zone_current_limiter_test.sv
`timescale 1ns / 1ps
// testbench for thermal_zone_current_limiter: directed and random temperature words,
// each result word checked against a zone predictor kept inside this module
// depends on tzcl_pkg and the limiter rtl

module thermal_zone_current_limiter_test;
	import tzcl_pkg::*;

	localparam int RING_DEPTH  = 5;
	localparam int REG_COUNT   = int'(CFG_CONFIRM) + 1;
	localparam int CNT_SAT     = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 20;   // margin beyond the pipeline depth
	localparam int MAX_REPORTS = 10;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [TEMP_W-1:0] temp_celsius = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ZONE_W-1:0]        zone;
	logic                     limited;
	logic [LIMIT_W-1:0]       current_limit_ma;
	logic signed [TEMP_W-1:0] average_celsius;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_idx = '0;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

	// predictor copy of the registers
	logic signed [TEMP_W-1:0] rise_one_thr, rise_two_thr, fall_zero_thr, fall_one_thr;
	logic [LIMIT_W-1:0]       limit_one_ma, limit_two_ma;
	logic [CNT_W-1:0]         confirm_need;

	// predictor copy of the state
	logic signed [TEMP_W-1:0] temp_ring [RING_DEPTH];
	int                       ring_slot;
	int                       prev_average;
	bit                       heading_up;
	logic [CNT_W-1:0]         qual_count [2][3];   // [rise or fall row][target zone]
	logic [ZONE_W-1:0]        zone_now;

	tzcl_result_t zone_expect_q [$];
	tzcl_result_t zone_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int words_checked = 0;
	int cycle_count = 0;

	thermal_zone_current_limiter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.temp_celsius     (temp_celsius),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.zone             (zone),
		.limited          (limited),
		.current_limit_ma (current_limit_ma),
		.average_celsius  (average_celsius),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver back-pressure, new decision every falling edge
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// every accepted result word is matched against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (zone_expect_q.size() == 0) begin
				report_error($sformatf("unexpected word: zone %0d ma %0d avg %0d",
					zone, current_limit_ma, average_celsius));
			end else begin
				zone_seen = zone_expect_q.pop_front();
				if ({zone, limited, current_limit_ma, average_celsius} !== zone_seen)
					report_error($sformatf(
						"word %0d: exp zone %0d lim %0d ma %0d avg %0d, got %0d %0d %0d %0d",
						words_checked, zone_seen.zone, zone_seen.limited, zone_seen.limit,
						zone_seen.avg, zone, limited, current_limit_ma, average_celsius));
				words_checked++;
			end
		end
	end

	function automatic logic signed [TEMP_W-1:0] clamp_temp(input int v);
		if (v > 255)
			return 9'sd255;
		if (v < -256)
			return -9'sd256;
		return v[TEMP_W-1:0];
	endfunction

	// one hit: the hit counter counts up (sticks at seven), all others clear
	task automatic bump_counter(input logic row, input logic [ZONE_W-1:0] col);
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 3; c++)
				if (r != row || c != col)
					qual_count[r][c] = '0;
		if (qual_count[row][col] != CNT_SAT)
			qual_count[row][col]++;
	endtask

	task automatic predict_zone(input logic signed [TEMP_W-1:0] t);
		int total, avg, need;
		tzcl_result_t r;
		temp_ring[ring_slot] = t;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		total = 0;
		foreach (temp_ring[k])
			total += temp_ring[k];
		// rounded mean, division truncates toward zero
		avg = (2 * total + RING_DEPTH) / (2 * RING_DEPTH);

		// direction is sticky across an unchanged average
		if (avg > prev_average)
			heading_up = 1'b1;
		else if (avg < prev_average)
			heading_up = 1'b0;
		prev_average = avg;

		// no qualification while the last ring slot does not hold a nonzero sample
		if (temp_ring[RING_DEPTH-1] != 0) begin
			if (heading_up) begin
				if (avg >= rise_two_thr)
					bump_counter(ROW_RISE, ZONE_HOT);
				else if (avg >= rise_one_thr && zone_now <= ZONE_MEDIUM)
					bump_counter(ROW_RISE, ZONE_MEDIUM);
			end else begin
				if (avg < fall_zero_thr && zone_now >= ZONE_MEDIUM)
					bump_counter(ROW_FALL, ZONE_NONE);
				else if (avg < fall_one_thr && zone_now == ZONE_HOT)
					bump_counter(ROW_FALL, ZONE_MEDIUM);
			end
		end

		// a confirm count of zero acts as one; later columns win
		need = (confirm_need == 0) ? 1 : confirm_need;
		for (int z = 0; z < 3; z++) begin
			if (qual_count[ROW_RISE][z] == need) begin
				zone_now = ZONE_W'(z);
				qual_count[ROW_RISE][z] = '0;
			end else if (qual_count[ROW_FALL][z] == need) begin
				zone_now = ZONE_W'(z);
				qual_count[ROW_FALL][z] = '0;
			end
		end

		r.zone = zone_now;
		r.limited = (zone_now != ZONE_NONE);
		r.limit = (zone_now == ZONE_MEDIUM) ? limit_one_ma :
			(zone_now == ZONE_HOT) ? limit_two_ma : '0;
		r.avg = avg[TEMP_W-1:0];
		zone_expect_q.push_back(r);
	endtask

	// offer one word, with random idle cycles ahead of it; returns on a falling edge
	task automatic send_temp(input logic signed [TEMP_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			temp_celsius = TEMP_W'($urandom);   // junk on the bus while idle
			@(negedge clk);
		end
		in_valid = 1'b1;
		temp_celsius = t;
		do
			@(posedge clk);
		while (!in_ready);
		predict_zone(t);
		@(negedge clk);
	endtask

	task automatic wait_drained;
		in_valid = 1'b0;
		while (zone_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// rewrite every register once the pipe is empty; bits above a register's width are junk
	task automatic load_regs(input int r1, input int r2, input int f0, input int f1,
		input int l1, input int l2, input int cc);
		int vals [REG_COUNT];
		logic [CFG_DATA_W-1:0] word;
		tzcl_cfg_idx_t idx;
		vals = '{r1, r2, f0, f1, l1, l2, cc};
		wait_drained();
		for (int i = 0; i < REG_COUNT; i++) begin
			idx = tzcl_cfg_idx_t'(i);
			word = CFG_DATA_W'($urandom);
			case (idx)
				CFG_LIMIT_ONE, CFG_LIMIT_TWO: word = vals[i][LIMIT_W-1:0];
				CFG_CONFIRM: word[CNT_W-1:0] = vals[i][CNT_W-1:0];
				default: word[TEMP_W-1:0] = vals[i][TEMP_W-1:0];
			endcase
			case (idx)
				CFG_RISE_TO_ONE:  rise_one_thr = word[TEMP_W-1:0];
				CFG_RISE_TO_TWO:  rise_two_thr = word[TEMP_W-1:0];
				CFG_FALL_TO_ZERO: fall_zero_thr = word[TEMP_W-1:0];
				CFG_FALL_TO_ONE:  fall_one_thr = word[TEMP_W-1:0];
				CFG_LIMIT_ONE:    limit_one_ma = word[LIMIT_W-1:0];
				CFG_LIMIT_TWO:    limit_two_ma = word[LIMIT_W-1:0];
				CFG_CONFIRM:      confirm_need = word[CNT_W-1:0];
				default: ;
			endcase
			cfg_wr_en = 1'b1;
			cfg_idx = idx;
			cfg_wdata = word;
			@(negedge clk);
		end
		cfg_wr_en = 1'b0;
	endtask

	// default thresholds and limits with a chosen confirm count
	task automatic load_default_regs(input int cc);
		load_regs(int'(RISE_TO_ONE_RST), int'(RISE_TO_TWO_RST), int'(FALL_TO_ZERO_RST),
			int'(FALL_TO_ONE_RST), int'(LIMIT_ONE_RST), int'(LIMIT_TWO_RST), cc);
	endtask

	// ordered thresholds with some overlap, any limits, any confirm count
	task automatic load_random_regs;
		int r1, r2;
		r1 = $urandom_range(110) + 20;
		r2 = r1 + $urandom_range(60);
		load_regs(r1, r2, r1 - int'($urandom_range(20)), r2 - int'($urandom_range(20)),
			$urandom_range(4095), $urandom_range(4095), $urandom_range(7));
	endtask

	// default registers: four ticks with an empty last slot, three rise-one hits
	// into zone one, three rise-two hits into zone two, then a cold drop and the
	// two ends of the 9-bit sample range
	task automatic test_ramp_through_zones;
		int ramp [$] = '{60, 60, 60, 60, 60, 60, 60, 200, 200, 200,
			-40, -40, -40, -256, 255};
		foreach (ramp[k])
			send_temp(TEMP_W'(ramp[k]));
	endtask

	// build a rise-two count under confirm seven, then drop confirm to one so the
	// counter is past it and runs into its ceiling without moving the zone
	task automatic test_counter_saturation;
		load_default_regs(7);
		repeat (5)
			send_temp(TEMP_W'(255));
		load_default_regs(1);
		repeat (4)
			send_temp(TEMP_W'(255));
	endtask

	// confirm of zero behaves like one
	task automatic test_confirm_zero;
		load_default_regs(0);
		send_temp(TEMP_W'(-40));
		send_temp(TEMP_W'(60));
		send_temp(TEMP_W'(60));
	endtask

	// mostly steady runs close to one threshold (or at zero) so counters reach confirm,
	// the rest in-range noise and raw 9-bit values
	task automatic test_random_traffic(input int items, input int send_pct,
		input int recv_pct);
		int sent, level, spread, run_len, pick;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(9);
			if (pick < 7) begin
				spread = 8;
				case ($urandom_range(4))
					0: level = int'(rise_one_thr);
					1: level = int'(rise_two_thr);
					2: level = int'(fall_zero_thr);
					3: level = int'(fall_one_thr);
					default: begin
						level = 0;   // zero run, exercises the empty-slot gate
						spread = 0;
					end
				endcase
				level = level + int'($urandom_range(2 * spread)) - spread;
				run_len = $urandom_range(3, 12);
				repeat (run_len) begin
					send_temp(clamp_temp(level + int'($urandom_range(2 * spread / 8)) -
						spread / 8));
					sent++;
				end
			end else if (pick < 9) begin
				send_temp(clamp_temp(int'($urandom_range(240)) - 40));
				sent++;
			end else begin
				send_temp(TEMP_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		// predictor starts from the reset image
		rise_one_thr = RISE_TO_ONE_RST;
		rise_two_thr = RISE_TO_TWO_RST;
		fall_zero_thr = FALL_TO_ZERO_RST;
		fall_one_thr = FALL_TO_ONE_RST;
		limit_one_ma = LIMIT_ONE_RST;
		limit_two_ma = LIMIT_TWO_RST;
		confirm_need = CONFIRM_RST;
		foreach (temp_ring[k])
			temp_ring[k] = '0;
		foreach (qual_count[r, c])
			qual_count[r][c] = '0;
		ring_slot = 0;
		prev_average = 0;
		heading_up = 1'b0;
		zone_now = ZONE_NONE;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ramp_through_zones();
		test_counter_saturation();
		test_confirm_zero();

		// free flow
		load_random_regs();
		test_random_traffic(225, 0, 0);
		// sender mostly idle, thresholds at the ends of the in-range noise, limits at their extremes
		load_regs(-40, 200, 200, -40, 4095, 0, 7);
		test_random_traffic(225, 83, 0);
		// receiver mostly stalled, full 9-bit thresholds, output queue fills
		load_regs(255, -256, -40, 200, 0, 4095, 1);
		test_random_traffic(225, 0, 83);
		// both sides idle a good part of the time
		load_random_regs();
		test_random_traffic(225, 38, 38);

		wait_drained();
		repeat (SETTLE) @(negedge clk);   // catch any stray trailing word
		if (error_count == 0 && zone_expect_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> thermal_zone_current_limiter.f
rtl/tzcl_pkg.sv
rtl/tzcl_ram.sv
rtl/tzcl_avg.sv
rtl/thermal_zone_current_limiter.sv
tb/thermal_zone_current_limiter_test.sv
